[hdl/pwm_frequency_duty_meter_defines.svh]
// ----------------------------------------------------------------------------
// PWM frequency/duty meter assertion macros
// Shared concurrent-assertion wrappers, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PWM_FREQUENCY_DUTY_METER_DEFINES_SVH
`define PWM_FREQUENCY_DUTY_METER_DEFINES_SVH

// cond must hold at every edge out of reset
`define PFDM_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define PFDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PFDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/pfdm_pkg.sv]
// ----------------------------------------------------------------------------
// PWM frequency/duty meter package
// Widths, reset values, phase codes and sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pfdm_pkg;

	localparam int TIMER_WIDTH_DEF = 16;
	localparam int CLK_HZ_W        = 27;
	localparam int DUTY_W          = 10;
	localparam int DUTY_SCALE      = 1000;

	localparam logic [CLK_HZ_W-1:0] CLK_HZ_RESET = 27'd16000000;

	localparam logic [1:0] PH_RISE1  = 2'd0;
	localparam logic [1:0] PH_FALL   = 2'd1;
	localparam logic [1:0] PH_RISE2  = 2'd2;
	localparam logic [1:0] PH_UNUSED = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_FREQ = 3'b010,
		ST_DUTY = 3'b100
	} seq_state_t;

endpackage

`default_nettype wire

[hdl/pfdm_if.sv]
// ----------------------------------------------------------------------------
// PWM frequency/duty meter channels
// Valid/ready capture input channel and measurement result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfdm_capture_if
	import pfdm_pkg::*;
#(
	parameter int TW = TIMER_WIDTH_DEF
);
	logic          valid;
	logic          ready;
	logic [TW-1:0] capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink   (input valid, input capture_time, output ready);
endinterface

interface pfdm_result_if
	import pfdm_pkg::*;
#(
	parameter int TW = TIMER_WIDTH_DEF
);
	logic                valid;
	logic                ready;
	logic                measurement_valid;
	logic                period_error;
	logic [TW-1:0]       high_ticks;
	logic [TW-1:0]       period_ticks;
	logic [CLK_HZ_W-1:0] frequency_hz;
	logic [DUTY_W-1:0]   duty_tenths;
	logic                next_edge_rising;

	modport source (
		output valid, output measurement_valid, output period_error,
		output high_ticks, output period_ticks, output frequency_hz,
		output duty_tenths, output next_edge_rising, input ready
	);
	modport sink (
		input valid, input measurement_valid, input period_error,
		input high_ticks, input period_ticks, input frequency_hz,
		input duty_tenths, input next_edge_rising, output ready
	);
endinterface

`default_nettype wire

[hdl/pwm_frequency_duty_meter.sv]
// ----------------------------------------------------------------------------
// PWM frequency and duty meter
// Input-capture based period, high time, frequency and duty measurement.
// ----------------------------------------------------------------------------
// Captures arrive in the order rise, fall, rise. The first two beats return a
// result in the next cycle (measurement_valid low). The closing rise runs two
// divisions through one shared radix-2 divider of DW = max(27, TIMER_WIDTH+10)
// bits, one quotient bit per cycle: clock_hz / period, then 1000 * high /
// period. capture.ready stays low while the divisions run. A zero period skips
// the divider and reports period_error in the next cycle. clock_hz may be
// written only while no measurement is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pwm_frequency_duty_meter_defines.svh"

module pwm_frequency_duty_meter
	import pfdm_pkg::*;
#(
	parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	pfdm_capture_if.sink             capture,
	pfdm_result_if.source            result,
	input  wire logic                cfg_we,
	input  wire logic [CLK_HZ_W-1:0] cfg_wdata
);

	localparam int PW = TIMER_WIDTH + 10;
	localparam int DW = (PW > CLK_HZ_W) ? PW : CLK_HZ_W;

	seq_state_t          state_q;
	logic [1:0]          capture_phase_q;
	logic                out_valid_q;
	logic                start_q;
	logic [CLK_HZ_W-1:0] clock_hz_q;

	logic [TIMER_WIDTH-1:0] first_rise_q;
	logic [TIMER_WIDTH-1:0] fall_time_q;
	logic [PW-1:0]          prod_q;

	logic                   res_meas_q;
	logic                   res_err_q;
	logic [TIMER_WIDTH-1:0] res_high_q;
	logic [TIMER_WIDTH-1:0] res_period_q;
	logic [CLK_HZ_W-1:0]    res_freq_q;
	logic [DUTY_W-1:0]      res_duty_q;
	logic                   res_next_q;

	logic                   accept;
	logic [TIMER_WIDTH-1:0] high_w;
	logic [TIMER_WIDTH-1:0] period_w;
	logic [DW-1:0]          div_dividend;
	logic                   div_done;
	logic [DW-1:0]          div_quot;
	logic [DUTY_W-1:0]      duty_sat;

	assign capture.ready = (state_q == ST_IDLE) && (!out_valid_q || result.ready);
	assign accept        = capture.valid && capture.ready;

	assign high_w   = fall_time_q - first_rise_q;
	assign period_w = capture.capture_time - first_rise_q;

	assign div_dividend = (state_q == ST_FREQ) ? DW'(clock_hz_q) : DW'(prod_q);
	assign duty_sat     = (div_quot > DW'(DUTY_SCALE)) ? DUTY_W'(DUTY_SCALE)
	                                                   : div_quot[DUTY_W-1:0];

	pfdm_div #(
		.DW(DW),
		.VW(TIMER_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_q),
		.dividend(div_dividend),
		.divisor (res_period_q),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			capture_phase_q <= PH_RISE1;
			out_valid_q     <= 1'b0;
			start_q         <= 1'b0;
			clock_hz_q      <= CLK_HZ_RESET;
		end else begin
			start_q <= 1'b0;
			if (cfg_we) begin
				clock_hz_q <= cfg_wdata;
			end
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (capture_phase_q)
							PH_FALL: begin
								capture_phase_q <= PH_RISE2;
								out_valid_q     <= 1'b1;
							end
							PH_RISE2: begin
								capture_phase_q <= PH_RISE1;
								if (period_w != '0) begin
									state_q <= ST_FREQ;
									start_q <= 1'b1;
								end else begin
									out_valid_q <= 1'b1;
								end
							end
							default: begin
								capture_phase_q <= PH_FALL;
								out_valid_q     <= 1'b1;
							end
						endcase
					end
				end
				ST_FREQ: begin
					if (div_done) begin
						state_q <= ST_DUTY;
						start_q <= 1'b1;
					end
				end
				ST_DUTY: begin
					if (div_done) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			case (capture_phase_q)
				PH_FALL: begin
					fall_time_q  <= capture.capture_time;
					res_meas_q   <= 1'b0;
					res_err_q    <= 1'b0;
					res_high_q   <= '0;
					res_period_q <= '0;
					res_freq_q   <= '0;
					res_duty_q   <= '0;
					res_next_q   <= 1'b1;
				end
				PH_RISE2: begin
					prod_q       <= PW'(high_w) * PW'(DUTY_SCALE);
					res_meas_q   <= 1'b1;
					res_err_q    <= (period_w == '0);
					res_high_q   <= high_w;
					res_period_q <= period_w;
					res_freq_q   <= '0;
					res_duty_q   <= '0;
					res_next_q   <= 1'b1;
				end
				default: begin
					first_rise_q <= capture.capture_time;
					res_meas_q   <= 1'b0;
					res_err_q    <= 1'b0;
					res_high_q   <= '0;
					res_period_q <= '0;
					res_freq_q   <= '0;
					res_duty_q   <= '0;
					res_next_q   <= 1'b0;
				end
			endcase
		end
		if ((state_q == ST_FREQ) && div_done) begin
			res_freq_q <= div_quot[CLK_HZ_W-1:0];
		end
		if ((state_q == ST_DUTY) && div_done) begin
			res_duty_q <= duty_sat;
		end
	end

	assign result.valid             = out_valid_q;
	assign result.measurement_valid = res_meas_q;
	assign result.period_error      = res_err_q;
	assign result.high_ticks        = res_high_q;
	assign result.period_ticks      = res_period_q;
	assign result.frequency_hz      = res_freq_q;
	assign result.duty_tenths       = res_duty_q;
	assign result.next_edge_rising  = res_next_q;

	`PFDM_ASSERT_ALWAYS(a_phase_legal, clk, arst_n, capture_phase_q != PH_UNUSED, "unused capture phase reached")
	`PFDM_ASSERT_IMP(a_div_done_busy, clk, arst_n, div_done, (state_q == ST_FREQ) || (state_q == ST_DUTY), "divider done outside a division")
	`PFDM_ASSERT_NEXT(a_duty_result, clk, arst_n, (state_q == ST_DUTY) && div_done, out_valid_q && res_meas_q && !res_err_q, "finished measurement not presented")
	`PFDM_ASSERT_IMP(a_duty_range, clk, arst_n, out_valid_q, res_duty_q <= DUTY_W'(DUTY_SCALE), "duty above full scale")

endmodule

`default_nettype wire

[hdl/pfdm_div.sv]
// ----------------------------------------------------------------------------
// PWM frequency/duty meter divider
// Radix-2 restoring divider, one quotient bit per cycle, shared by the
// frequency and duty computations.
// ----------------------------------------------------------------------------
`default_nettype none

module pfdm_div
	import pfdm_pkg::*;
#(
	parameter int DW = CLK_HZ_W,
	parameter int VW = TIMER_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [VW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int CW = $clog2(DW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] acc_q;
	logic [VW-1:0] rem_q;

	logic [VW:0]   rem_sh;
	logic [VW+1:0] diff;
	logic          fits;

	assign rem_sh = {rem_q, acc_q[DW-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
	assign fits   = !diff[VW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[DW-2:0], fits};
			rem_q <= fits ? diff[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q;

endmodule

`default_nettype wire
